FILE: rtl/core/g711_pkg.sv
// Package with the G.711 operation codes and the A-law and mu-law conversion functions.
`default_nettype none

package g711_pkg;

  // Operation selected by the kind field of a request
  typedef enum logic [2:0] {
    KIND_ALAW_DEC  = 3'd0,
    KIND_ALAW_ENC  = 3'd1,
    KIND_ULAW_DEC  = 3'd2,
    KIND_ULAW_ENC  = 3'd3,
    KIND_ALAW2ULAW = 3'd4,
    KIND_ULAW2ALAW = 3'd5
  } kind_e;

  localparam logic [7:0]         AlawXorMask  = 8'h55;
  localparam logic [15:0]        UlawBias     = 16'h0084;
  localparam logic signed [15:0] UlawClip     = 16'sd32635;
  localparam logic [7:0]         UlawSilentNeg = 8'h7F;
  localparam logic signed [15:0] AlawMinIn    = -16'sd32767;

  // A-law code to linear sample. The magnitude is never zero.
  function automatic logic signed [15:0] alaw_decode(input logic [7:0] code);
    logic [7:0]  t;
    logic [2:0]  seg;
    logic [7:0]  mag0;
    logic [14:0] mag;
    t    = code ^ AlawXorMask;
    seg  = t[6:4];
    mag0 = {t[3:0], 4'h8};
    if (seg != 3'd0) begin
      mag = 15'({1'b1, mag0}) << (seg - 3'd1);
    end else begin
      mag = 15'(mag0);
    end
    alaw_decode = t[7] ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
  endfunction

  // Linear sample to A-law code; the most negative sample is moved up by one.
  function automatic logic [7:0] alaw_encode(input logic signed [15:0] x);
    logic signed [15:0] xc;
    logic               neg;
    logic [15:0]        mag;
    logic [6:0]         hb;
    logic [2:0]         seg;
    logic [3:0]         shift;
    logic [3:0]         mant;
    logic [7:0]         flip;
    xc  = (x < AlawMinIn) ? AlawMinIn : x;
    neg = xc[15];
    mag = neg ? 16'(-xc) : 16'(xc);
    hb  = mag[14:8];
    seg = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (hb[i]) begin
        seg = 3'(i + 1);
      end
    end
    shift = (seg != 3'd0) ? ({1'b0, seg} + 4'd3) : 4'd4;
    mant  = 4'(mag >> shift);
    flip  = neg ? AlawXorMask : (AlawXorMask | 8'h80);
    alaw_encode = {1'b0, seg, mant} ^ flip;
  endfunction

  // Mu-law code to linear sample; the negative silence code gives minus one.
  function automatic logic signed [15:0] ulaw_decode(input logic [7:0] code);
    logic [7:0]  t;
    logic [2:0]  seg;
    logic [3:0]  mant;
    logic [15:0] mag;
    t    = ~code;
    seg  = t[6:4];
    mant = t[3:0];
    mag  = (UlawBias << seg) - UlawBias + (16'(mant) << ({1'b0, seg} + 4'd3));
    if (code == UlawSilentNeg) begin
      ulaw_decode = -16'sd1;
    end else begin
      ulaw_decode = t[7] ? -$signed(mag) : $signed(mag);
    end
  endfunction

  // Linear sample to mu-law code, with the sample clipped symmetrically.
  function automatic logic [7:0] ulaw_encode(input logic signed [15:0] x);
    logic signed [15:0] xc;
    logic               sign;
    logic [15:0]        mag;
    logic [15:0]        b;
    logic [2:0]         seg;
    logic [3:0]         mant;
    xc = x;
    if (xc < -UlawClip) begin
      xc = -UlawClip;
    end
    if (xc > UlawClip) begin
      xc = UlawClip;
    end
    sign = xc[15];
    mag  = sign ? 16'(-xc) : 16'(xc);
    b    = mag + UlawBias;
    seg  = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (b[8 + i]) begin
        seg = 3'(i + 1);
      end
    end
    mant = 4'(b >> ({1'b0, seg} + 4'd3));
    ulaw_encode = ~{sign, seg, mant};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/g711_alaw_ulaw_codec_unit.sv
// Top level of the G.711 A-law and mu-law codec unit.
// A request accepted into the input register goes through the conversion logic to the result register,
// and done_o is high for one cycle when its result appears.
// Throughput: one request per cycle; busy is held low since both register stages advance
// every cycle and the receiver takes each result in the cycle it appears.
// Reset (rst_ni low) clears the stage valid flags at once; results in flight are dropped, none is invented.
`default_nettype none

module g711_alaw_ulaw_codec_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         kind_i,
  input  wire logic signed [15:0] sample_in_i,
  input  wire logic [7:0]         code_in_i,
  output logic                    done_o,
  output logic signed [15:0]      sample_out_o,
  output logic [7:0]              code_out_o
);

  logic               accept;
  logic               in_vld_q;
  logic [2:0]         kind_q;
  logic signed [15:0] sample_q;
  logic [7:0]         code_q;
  logic signed [15:0] sample_d;
  logic [7:0]         code_d;
  logic               out_vld_q;
  logic signed [15:0] sample_out_q;
  logic [7:0]         code_out_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= accept;
      out_vld_q <= in_vld_q;
    end
  end

  // Input register captures the request fields.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_i;
      sample_q <= sample_in_i;
      code_q   <= code_in_i;
    end
  end

  g711_conv u_conv (
    .kind_i   (kind_q),
    .sample_i (sample_q),
    .code_i   (code_q),
    .sample_o (sample_d),
    .code_o   (code_d)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      sample_out_q <= sample_d;
      code_out_q   <= code_d;
    end
  end

  assign done_o       = out_vld_q;
  assign sample_out_o = sample_out_q;
  assign code_out_o   = code_out_q;

  // A result only appears for an earlier accepted request.
  a_done_follows_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 2))
    else $error("result strobe without an accepted request");

  // Every accepted request yields a result.
  a_req_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_o)
    else $error("accepted request produced no result");

  // Decode operations leave the code field zero.
  a_decode_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(kind_i, 2) == g711_pkg::KIND_ALAW_DEC ||
                $past(kind_i, 2) == g711_pkg::KIND_ULAW_DEC)) |-> code_out_o == 8'h00)
    else $error("decode result has a nonzero code");

  // Encode and transcode operations leave the sample field zero.
  a_encode_sample_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(kind_i, 2) == g711_pkg::KIND_ALAW_ENC ||
                $past(kind_i, 2) == g711_pkg::KIND_ULAW_ENC ||
                $past(kind_i, 2) == g711_pkg::KIND_ALAW2ULAW ||
                $past(kind_i, 2) == g711_pkg::KIND_ULAW2ALAW)) |-> sample_out_o == 16'sd0)
    else $error("encode result has a nonzero sample");

  // A-law decode never produces a zero sample.
  a_alaw_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(kind_i, 2) == g711_pkg::KIND_ALAW_DEC) |-> sample_out_o != 16'sd0)
    else $error("A-law decode gave a zero sample");

endmodule

`default_nettype wire

FILE: rtl/core/g711_conv.sv
// Combinational G.711 datapath that performs one of the six conversions.
`default_nettype none

module g711_conv (
  input  wire logic [2:0]         kind_i,
  input  wire logic signed [15:0] sample_i,
  input  wire logic [7:0]         code_i,
  output logic signed [15:0]      sample_o,
  output logic [7:0]              code_o
);

  logic signed [15:0] alaw_lin;
  logic signed [15:0] ulaw_lin;

  // Shared decoders feed both the decode and the transcode operations.
  assign alaw_lin = g711_pkg::alaw_decode(code_i);
  assign ulaw_lin = g711_pkg::ulaw_decode(code_i);

  // Select the operation; the field that an operation does not produce is zero.
  always_comb begin
    sample_o = '0;
    code_o   = '0;
    case (kind_i)
      g711_pkg::KIND_ALAW_DEC:  sample_o = alaw_lin;
      g711_pkg::KIND_ALAW_ENC:  code_o   = g711_pkg::alaw_encode(sample_i);
      g711_pkg::KIND_ULAW_DEC:  sample_o = ulaw_lin;
      g711_pkg::KIND_ULAW_ENC:  code_o   = g711_pkg::ulaw_encode(sample_i);
      g711_pkg::KIND_ALAW2ULAW: code_o   = g711_pkg::ulaw_encode(alaw_lin);
      g711_pkg::KIND_ULAW2ALAW: code_o   = g711_pkg::alaw_encode(ulaw_lin);
      default: begin
        sample_o = '0;
        code_o   = '0;
      end
    endcase
  end

endmodule

`default_nettype wire
